// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/fba_pkg.sv =====
package fba_pkg;

  // Map geometry
  localparam int MAP_WORDS      = 128;
  localparam int WORD_W         = 32;
  localparam int WIDX_W         = $clog2(MAP_WORDS);
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int EDGE_W         = BIT_W + 1;
  localparam int FRAME_W        = WIDX_W + BIT_W;
  localparam int FRAME_CAPACITY = MAP_WORDS * WORD_W;

  // Field widths
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int OUT_ADDR_W = 24;
  localparam int COUNT_W    = 13;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic scan;
    logic rebuild;
    logic free_rd;
    logic free_wr;
    logic load_out;
  } fba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic rebuild_done;
    logic out_free;
  } fba_sts_t;

endpackage

// ===== hdl/fba_datapath.sv =====
module fba_datapath import fba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fba_cmd_t               cmd,
  output fba_sts_t               sts,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_ADDR_W-1:0]  out_frame_address,
  output logic                   out_granted,
  output logic [COUNT_W-1:0]     out_used_count
);

  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  // Bit position where a frame bound falls inside the word starting at base
  function automatic logic [EDGE_W-1:0] word_edge(input logic [COUNT_W-1:0] bound,
                                                  input logic [COUNT_W-1:0] base);
    logic [COUNT_W-1:0] diff;
    diff = bound - base;
    if (bound <= base) begin
      word_edge = '0;
    end else if (diff >= COUNT_W'(WORD_W)) begin
      word_edge = EDGE_W'(WORD_W);
    end else begin
      word_edge = diff[EDGE_W-1:0];
    end
  endfunction

  // Frame map storage; an entry not yet written reads as all used
  logic [WORD_W-1:0]  mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;

  logic [COUNT_W-1:0]    frame_count_r, reserved_r, used_r;
  logic [WIDX_W-1:0]     ptr_r, rd_word_r;
  logic [WORD_W-1:0]     rd_data_r;
  logic                  rd_vld_r, rd_pend_r;
  logic [FRAME_W-1:0]    free_frame_r;
  logic                  free_ok_r;
  logic [OUT_ADDR_W-1:0] res_addr_r;
  logic                  res_grant_r;
  logic                  out_valid_r;
  logic [OUT_ADDR_W-1:0] out_addr_r;
  logic                  out_grant_r;
  logic [COUNT_W-1:0]    out_used_r;

  logic [COUNT_W-1:0]  lim;
  logic [WORD_W-1:0]   scan_word, free_word, reb_word;
  logic [BIT_W-1:0]    zero_idx, free_bit;
  logic [FRAME_W-1:0]  scan_frame, in_frame;
  logic                scan_hit, scan_ok, scan_grant, free_hit;
  logic [COUNT_W-1:0]  base;
  logic [EDGE_W-1:0]   lo, hi;
  logic                wr_en, rd_en;
  logic [WIDX_W-1:0]   wr_addr, rd_addr;
  logic [WORD_W-1:0]   wr_data;

  // Frame limit saturated to capacity
  assign lim = (frame_count_r > COUNT_W'(FRAME_CAPACITY)) ?
               COUNT_W'(FRAME_CAPACITY) : frame_count_r;

  // Scan: lowest clear bit of the word read last cycle
  assign scan_word = rd_vld_r ? rd_data_r : '1;
  assign scan_hit  = rd_pend_r && (scan_word != '1);
  always_comb begin
    zero_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) zero_idx = BIT_W'(i);
    end
  end
  assign scan_frame = {rd_word_r, zero_idx};
  assign scan_ok    = COUNT_W'(scan_frame) < lim;
  assign scan_grant = cmd.scan && scan_hit && scan_ok;

  // Rebuild: free bits of word ptr_r that fall in [reserved, limit)
  assign base = COUNT_W'({ptr_r, BIT_W'(0)});
  assign lo   = word_edge(reserved_r, base);
  assign hi   = word_edge(lim, base);
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      reb_word[b] = !((EDGE_W'(b) >= lo) && (EDGE_W'(b) < hi));
    end
  end

  // Free: test and clear the requested bit
  assign in_frame  = in_address[PAGE_SHIFT+FRAME_W-1:PAGE_SHIFT];
  assign free_word = rd_vld_r ? rd_data_r : '1;
  assign free_bit  = free_frame_r[BIT_W-1:0];
  assign free_hit  = cmd.free_wr && free_ok_r && free_word[free_bit];

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = reb_word;
    if (scan_grant) begin
      wr_en   = 1'b1;
      wr_addr = rd_word_r;
      wr_data = scan_word | (WORD_W'(1) << zero_idx);
    end else if (cmd.rebuild) begin
      wr_en   = 1'b1;
    end else if (free_hit) begin
      wr_en   = 1'b1;
      wr_addr = free_frame_r[FRAME_W-1:BIT_W];
      wr_data = free_word & ~(WORD_W'(1) << free_bit);
    end
  end
  assign rd_en   = cmd.scan || cmd.free_rd;
  assign rd_addr = cmd.scan ? ptr_r : free_frame_r[FRAME_W-1:BIT_W];

  // Map memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.scan) begin
      rd_word_r <= ptr_r;
    end
  end

  // Written-word flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      reserved_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count_r <= cfg_data;
        REG_RESERVED:    reserved_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sweep pointer and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else if (cmd.accept) begin
      ptr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (cmd.scan || cmd.rebuild) ptr_r <= ptr_r + WIDX_W'(1);
      if (cmd.scan) rd_pend_r <= 1'b1;
    end
  end

  // Used-frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (scan_grant) begin
      used_r <= used_r + COUNT_W'(1);
    end else if (cmd.rebuild && ptr_r == LAST_WORD) begin
      used_r <= reserved_r;
    end else if (free_hit) begin
      used_r <= used_r - COUNT_W'(1);
    end
  end

  // Request capture and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      free_frame_r <= in_frame;
      free_ok_r    <= (in_address[ADDR_W-1:PAGE_SHIFT+FRAME_W] == '0) &&
                      (COUNT_W'(in_frame) < lim);
      res_addr_r   <= '0;
      res_grant_r  <= 1'b0;
    end else if (scan_grant) begin
      res_addr_r   <= OUT_ADDR_W'({scan_frame, {PAGE_SHIFT{1'b0}}});
      res_grant_r  <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr_r  <= res_addr_r;
      out_grant_r <= res_grant_r;
      out_used_r  <= used_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_granted       = out_grant_r;
  assign out_used_count    = out_used_r;

  // Status
  assign sts.scan_done    = cmd.scan && rd_pend_r && (scan_hit || rd_word_r == LAST_WORD);
  assign sts.rebuild_done = cmd.rebuild && (ptr_r == LAST_WORD);
  assign sts.out_free     = !out_valid_r || out_ready;

endmodule

// ===== hdl/fba_ctrl.sv =====
module fba_ctrl import fba_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_op,
  input  fba_sts_t        sts,
  output fba_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_REBUILD = 6'b000100,
    S_FREE_RD = 6'b001000,
    S_FREE_WR = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_ALLOC:   state_nxt = S_SCAN;
            OP_FREE:    state_nxt = S_FREE_RD;
            OP_REBUILD: state_nxt = S_REBUILD;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_RESP;
      end
      S_REBUILD: begin
        cmd.rebuild = 1'b1;
        if (sts.rebuild_done) state_nxt = S_RESP;
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/frame_bitmap_allocator_top.sv =====
// Bitmap page-frame allocator: one bit per 4 KB frame (1 = used), 128 words of
// 32 bits held in a single-port-write, registered-read memory. One request is
// processed at a time. Allocate scans the map one word per cycle and stops at
// the first word with a clear bit or at the last word; rebuild sweeps all 128
// words; free reads the word holding the frame, then clears its bit if the frame
// is in range; the unused opcode goes straight to the response. The output register
// lets the next request be accepted while a result waits. After reset the map
// reads as all used and the frame limit is 0: program frame_count and
// reserved_frames, then issue a rebuild. Configuration writes must only occur
// while no request is in flight.
`include "assert_macros.svh"

module frame_bitmap_allocator_top import fba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        in_op,
  input  logic [ADDR_W-1:0]      in_address,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_ADDR_W-1:0]  out_frame_address,
  output logic                   out_granted,
  output logic [COUNT_W-1:0]     out_used_count,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data
);

  fba_cmd_t cmd;
  fba_sts_t sts;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  fba_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_address        (in_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_frame_address (out_frame_address),
    .out_granted       (out_granted),
    .out_used_count    (out_used_count)
  );

  // One request in flight: the block is busy right after accepting
  `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
  // Granted addresses are page aligned
  `ASSERT_IMPL(a_page_aligned, clk, rst_n, out_valid, out_frame_address[PAGE_SHIFT-1:0] == '0)
  // A result without a grant carries address zero
  `ASSERT_IMPL(a_no_grant_zero, clk, rst_n, out_valid && !out_granted, out_frame_address == '0)
  // An output load is issued only while a request is running
  `ASSERT_IMPL(a_load_not_idle, clk, rst_n, cmd.load_out, !in_ready)

endmodule
